[rtl/rscd_pkg.sv]
// Package for the range scan character decoder.
// Holds the line and holdback constants, register indexes and shared types.
`timescale 1ns / 1ps

package rscd_pkg;

  localparam int LINE_DATA_BYTES = 64;
  localparam int HOLDBACK_DEPTH  = 3;

  localparam int LINE_LENGTH = LINE_DATA_BYTES + 2;
  localparam int POS_W       = $clog2(LINE_LENGTH);
  localparam int FILL_W      = $clog2(HOLDBACK_DEPTH + 1);

  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 6;
  localparam int VALUE_W  = 18;
  localparam int DIST_W   = 19;
  localparam int COUNT_W  = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0]  DIGIT_BASE  = 8'h30;
  localparam logic [VALUE_W-1:0] NEAR_RESET  = 18'd20;
  localparam logic [VALUE_W-1:0] FAR_RESET   = 18'd8000;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT  = 1'd1;

  typedef struct packed {
    logic [VALUE_W-1:0] near_limit;
    logic [VALUE_W-1:0] far_limit;
  } rscd_limits_t;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } rscd_item_t;

endpackage

[rtl/range_scan_char_decoder.sv]
// Top level of the range scan character decoder.
// Holds the limit registers and joins rscd_gather and rscd_limit. Uses rscd_pkg.
//
//   channel  signals                                  direction
//   input    in_valid, in_stall, in_byte, is_last      byte in, stall out
//   output   out_valid, out_stall, distance,           item out, stall in
//            scan_done, point_count
//   config   cfg_write, cfg_index, cfg_data            write only
//
// One byte is taken in every cycle while in_stall is low.
// The pipeline is the gather register followed by the output register.
// Both stages move together whenever the output register is empty or being taken.
// Reset clears the scan state and loads the limits with 20 and 8000.
`timescale 1ns / 1ps

module range_scan_char_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rscd_pkg::CHAR_W-1:0]          in_byte,
  input  logic                                 is_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rscd_pkg::DIST_W-1:0]   distance,
  output logic                                 scan_done,
  output logic [rscd_pkg::COUNT_W-1:0]         point_count,
  input  logic                                 cfg_write,
  input  logic [rscd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rscd_pkg::VALUE_W-1:0]         cfg_data
);
  import rscd_pkg::*;

  rscd_limits_t limits;
  rscd_item_t   item;
  logic         advance;
  logic         accept;

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.near_limit <= NEAR_RESET;
      limits.far_limit <= FAR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NEAR_LIMIT: limits.near_limit <= cfg_data;
        REG_FAR_LIMIT:  limits.far_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rscd_gather u_gather (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .accept  (accept),
    .in_byte (in_byte),
    .is_last (is_last),
    .item    (item)
  );

  rscd_limit u_limit (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .limits      (limits),
    .out_valid   (out_valid),
    .distance    (distance),
    .scan_done   (scan_done),
    .point_count (point_count)
  );

endmodule

[rtl/rscd_gather.sv]
// Line position tracking, character holdback and digit gathering.
// Produces at most one registered raw value or end-of-scan item per accepted byte. Uses rscd_pkg.
`timescale 1ns / 1ps

module rscd_gather (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      accept,
  input  logic [rscd_pkg::CHAR_W-1:0] in_byte,
  input  logic                      is_last,
  output rscd_pkg::rscd_item_t      item
);
  import rscd_pkg::*;

  logic [POS_W-1:0]   line_position, line_position_next;
  logic [CHAR_W-1:0]  holdback_chars [HOLDBACK_DEPTH];
  logic [CHAR_W-1:0]  holdback_chars_next [HOLDBACK_DEPTH];
  logic [FILL_W-1:0]  holdback_fill, holdback_fill_next;
  logic [1:0]         digit_index, digit_index_next;
  logic [VALUE_W-1:0] partial_value, partial_value_next;
  logic [COUNT_W-1:0] points_so_far, points_so_far_next;
  rscd_item_t         item_next;
  logic [CHAR_W-1:0]  offset_char;
  logic [VALUE_W-1:0] shifted_value;

  always_comb begin
    line_position_next = line_position;
    holdback_chars_next = holdback_chars;
    holdback_fill_next = holdback_fill;
    digit_index_next = digit_index;
    partial_value_next = partial_value;
    points_so_far_next = points_so_far;
    item_next = '0;
    offset_char = holdback_chars[0] - DIGIT_BASE;
    shifted_value = {partial_value[VALUE_W-DIGIT_W-1:0], offset_char[DIGIT_W-1:0]};

    if (accept) begin
      if (is_last) begin
        item_next.valid = 1'b1;
        item_next.done = 1'b1;
        item_next.count = points_so_far;
        line_position_next = '0;
        for (int k = 0; k < HOLDBACK_DEPTH; k++) begin
          holdback_chars_next[k] = '0;
        end
        holdback_fill_next = '0;
        digit_index_next = '0;
        partial_value_next = '0;
        points_so_far_next = '0;
      end else begin
        if (line_position == POS_W'(LINE_LENGTH - 1)) begin
          line_position_next = '0;
        end else begin
          line_position_next = line_position + 1'b1;
        end
        if (line_position < POS_W'(LINE_DATA_BYTES) && in_byte != CHAR_SPACE) begin
          if (holdback_fill < FILL_W'(HOLDBACK_DEPTH)) begin
            for (int k = 0; k < HOLDBACK_DEPTH; k++) begin
              if (holdback_fill == FILL_W'(k)) begin
                holdback_chars_next[k] = in_byte;
              end
            end
            holdback_fill_next = holdback_fill + 1'b1;
          end else begin
            for (int k = 0; k < HOLDBACK_DEPTH - 1; k++) begin
              holdback_chars_next[k] = holdback_chars[k + 1];
            end
            holdback_chars_next[HOLDBACK_DEPTH - 1] = in_byte;
            if (digit_index < 2'd2) begin
              digit_index_next = digit_index + 1'b1;
              partial_value_next = shifted_value;
            end else begin
              item_next.valid = 1'b1;
              item_next.value = shifted_value;
              digit_index_next = '0;
              partial_value_next = '0;
              if (points_so_far != COUNT_MAX) begin
                points_so_far_next = points_so_far + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      for (int k = 0; k < HOLDBACK_DEPTH; k++) begin
        holdback_chars[k] <= '0;
      end
      holdback_fill <= '0;
      digit_index <= '0;
      partial_value <= '0;
      points_so_far <= '0;
    end else begin
      line_position <= line_position_next;
      holdback_chars <= holdback_chars_next;
      holdback_fill <= holdback_fill_next;
      digit_index <= digit_index_next;
      partial_value <= partial_value_next;
      points_so_far <= points_so_far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item <= '0;
    end else if (advance) begin
      item <= item_next;
    end
  end

endmodule

[rtl/rscd_limit.sv]
// Range limiting of a raw value and the output register.
// Takes items from rscd_gather and the limits from the top level. Uses rscd_pkg.
`timescale 1ns / 1ps

module rscd_limit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  rscd_pkg::rscd_item_t                item,
  input  rscd_pkg::rscd_limits_t              limits,
  output logic                                out_valid,
  output logic signed [rscd_pkg::DIST_W-1:0]  distance,
  output logic                                scan_done,
  output logic [rscd_pkg::COUNT_W-1:0]        point_count
);
  import rscd_pkg::*;

  logic signed [DIST_W-1:0] distance_next;

  always_comb begin
    if (item.done) begin
      distance_next = '0;
    end else if (item.value == '0) begin
      distance_next = DIST_W'(limits.far_limit);
    end else if (item.value < limits.near_limit) begin
      distance_next = '1;
    end else if (item.value > limits.far_limit) begin
      distance_next = DIST_W'(limits.far_limit);
    end else begin
      distance_next = DIST_W'(item.value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      distance <= distance_next;
      scan_done <= item.done;
      point_count <= item.done ? item.count : '0;
    end
  end

endmodule
